// ----- design/bbwq_pkg.sv -----
`default_nettype none

package bbwq_pkg;

    localparam int DATA_BITS = 8;
    localparam int OUTC_W    = 3;
    localparam int FILL_W    = 4;
    localparam int IDX_W     = 3;
    localparam int BPROD_W   = 5;
    localparam int BCONS_W   = 8;

    localparam logic [BCONS_W-1:0] CONSUMER_MAX = 8'hFF;

    localparam logic OP_PRODUCE = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    typedef enum logic [OUTC_W-1:0] {
        OUTC_STORED        = 3'd0,
        OUTC_PROD_BLOCKED  = 3'd1,
        OUTC_PROD_DROPPED  = 3'd2,
        OUTC_CONSUMED      = 3'd3,
        OUTC_CONS_BLOCKED  = 3'd4,
        OUTC_CONS_SATURATE = 3'd5
    } outcome_t;

    typedef struct packed {
        logic                 operation;
        logic [DATA_BITS-1:0] data_value;
    } req_t;

    typedef struct packed {
        outcome_t             outcome;
        logic                 delivered_valid;
        logic [DATA_BITS-1:0] delivered_data;
        logic                 consumer_woken;
        logic                 producer_woken;
        logic [FILL_W-1:0]    fill_count;
        logic [IDX_W-1:0]     write_index;
        logic [IDX_W-1:0]     read_index;
        logic [BPROD_W-1:0]   blocked_producers;
        logic [BCONS_W-1:0]   blocked_consumers;
    } rsp_t;

endpackage

`default_nettype wire

// ----- design/bbwq_ram.sv -----
`default_nettype none

module bbwq_ram #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 3
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/bounded_buffer_with_wait_queues.sv -----
// A result is computed in the EXEC state that follows acceptance and registered as the machine leaves EXEC.
// No new request is accepted until the current one leaves EXEC; the ring and wait-queue memories are
// read in the accept cycle and read-modified-written in the EXEC state.
// A request accepted while a result waits to be taken holds until the output frees.
// Reset clears the pointers, counters, state machine and output valid; the two
// memories are not cleared and hold nothing meaningful until written.
`default_nettype none

module bounded_buffer_with_wait_queues #(
    parameter int BUFFER_DEPTH = 8,
    parameter int WAIT_DEPTH   = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire bbwq_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output bbwq_pkg::rsp_t       rsp
);

    localparam int DW      = bbwq_pkg::DATA_BITS;
    localparam int PTR_W   = $clog2(BUFFER_DEPTH);
    localparam int CNT_W   = $clog2(BUFFER_DEPTH + 1);
    localparam int WPTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WCNT_W  = $clog2(WAIT_DEPTH + 1);
    localparam int WSUM_W  = WCNT_W + 1;
    localparam int FILL_W  = bbwq_pkg::FILL_W;
    localparam int IDX_W   = bbwq_pkg::IDX_W;
    localparam int BPROD_W = bbwq_pkg::BPROD_W;
    localparam int BCONS_W = bbwq_pkg::BCONS_W;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t               state_reg, state_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    bbwq_pkg::rsp_t       rsp_reg, rsp_next;
    logic                 op_reg, op_next;
    logic [DW-1:0]        data_reg, data_next;
    logic [PTR_W-1:0]     wpos_reg, wpos_next;
    logic [PTR_W-1:0]     rpos_reg, rpos_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WPTR_W-1:0]    whead_reg, whead_next;
    logic [WCNT_W-1:0]    wcnt_reg, wcnt_next;
    logic [BCONS_W-1:0]   cw_reg, cw_next;

    logic                 accept;
    logic                 ring_we;
    logic [PTR_W-1:0]     ring_waddr;
    logic [DW-1:0]        ring_wdata;
    logic [DW-1:0]        ring_rdata;
    logic                 wait_we;
    logic [DW-1:0]        wait_rdata;
    logic [WSUM_W-1:0]    wait_sum;
    logic [WPTR_W-1:0]    wait_tail;
    logic [PTR_W-1:0]     wpos_inc;
    logic [PTR_W-1:0]     rpos_inc;
    logic [WPTR_W-1:0]    whead_inc;
    logic                 ring_full;

    bbwq_pkg::outcome_t   outcome;
    logic                 dvalid;
    logic [DW-1:0]        ddata;
    logic                 cwoken;
    logic                 pwoken;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign wpos_inc  = (wpos_reg == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : wpos_reg + PTR_W'(1);
    assign rpos_inc  = (rpos_reg == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : rpos_reg + PTR_W'(1);
    assign whead_inc = (whead_reg == WPTR_W'(WAIT_DEPTH - 1)) ? '0 : whead_reg + WPTR_W'(1);
    assign ring_full = (cnt_reg == CNT_W'(BUFFER_DEPTH));

    // Tail of the wait queue: head plus count, folded once.
    assign wait_sum  = WSUM_W'(whead_reg) + WSUM_W'(wcnt_reg);
    assign wait_tail = (wait_sum >= WSUM_W'(WAIT_DEPTH))
                     ? WPTR_W'(wait_sum - WSUM_W'(WAIT_DEPTH))
                     : WPTR_W'(wait_sum);

    bbwq_ram #(
        .DEPTH  (BUFFER_DEPTH),
        .WIDTH  (DW),
        .ADDR_W (PTR_W)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (rpos_reg),
        .rdata (ring_rdata)
    );

    bbwq_ram #(
        .DEPTH  (WAIT_DEPTH),
        .WIDTH  (DW),
        .ADDR_W (WPTR_W)
    ) u_wait_ram (
        .clk   (clk),
        .we    (wait_we),
        .waddr (wait_tail),
        .wdata (data_reg),
        .raddr (whead_reg),
        .rdata (wait_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        op_next        = op_reg;
        data_next      = data_reg;
        wpos_next      = wpos_reg;
        rpos_next      = rpos_reg;
        cnt_next       = cnt_reg;
        whead_next     = whead_reg;
        wcnt_next      = wcnt_reg;
        cw_next        = cw_reg;
        ring_we        = 1'b0;
        ring_waddr     = wpos_reg;
        ring_wdata     = data_reg;
        wait_we        = 1'b0;
        outcome        = bbwq_pkg::OUTC_STORED;
        dvalid         = 1'b0;
        ddata          = '0;
        cwoken         = 1'b0;
        pwoken         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.operation;
                    data_next  = req.data_value;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Hold the request until the waiting result is taken; memory reads stay put.
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    if (op_reg == bbwq_pkg::OP_PRODUCE)
                    begin
                        if (!ring_full)
                        begin
                            ring_we   = 1'b1;
                            wpos_next = wpos_inc;
                            cnt_next  = cnt_reg + CNT_W'(1);
                            outcome   = bbwq_pkg::OUTC_STORED;
                        end
                        else if (wcnt_reg != WCNT_W'(WAIT_DEPTH))
                        begin
                            wait_we   = 1'b1;
                            wcnt_next = wcnt_reg + WCNT_W'(1);
                            outcome   = bbwq_pkg::OUTC_PROD_BLOCKED;
                        end
                        else
                        begin
                            outcome = bbwq_pkg::OUTC_PROD_DROPPED;
                        end
                        // Wake one consumer; on an empty ring it takes the value just stored.
                        if ((cw_reg != '0) && (cnt_next != '0))
                        begin
                            cw_next   = cw_reg - BCONS_W'(1);
                            dvalid    = 1'b1;
                            ddata     = (cnt_reg == '0) ? data_reg : ring_rdata;
                            cwoken    = 1'b1;
                            rpos_next = rpos_inc;
                            cnt_next  = cnt_next - CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            if (cw_reg == bbwq_pkg::CONSUMER_MAX)
                            begin
                                outcome = bbwq_pkg::OUTC_CONS_SATURATE;
                            end
                            else
                            begin
                                cw_next = cw_reg + BCONS_W'(1);
                                outcome = bbwq_pkg::OUTC_CONS_BLOCKED;
                            end
                        end
                        else
                        begin
                            dvalid    = 1'b1;
                            ddata     = ring_rdata;
                            rpos_next = rpos_inc;
                            cnt_next  = cnt_reg - CNT_W'(1);
                            outcome   = bbwq_pkg::OUTC_CONSUMED;
                        end
                        // Move the oldest waiting value into the ring.
                        if ((wcnt_reg != '0) && (cnt_next != CNT_W'(BUFFER_DEPTH)))
                        begin
                            ring_we    = 1'b1;
                            ring_wdata = wait_rdata;
                            wpos_next  = wpos_inc;
                            cnt_next   = cnt_next + CNT_W'(1);
                            whead_next = whead_inc;
                            wcnt_next  = wcnt_reg - WCNT_W'(1);
                            pwoken     = 1'b1;
                        end
                    end

                    rsp_next.outcome           = outcome;
                    rsp_next.delivered_valid   = dvalid;
                    rsp_next.delivered_data    = ddata;
                    rsp_next.consumer_woken    = cwoken;
                    rsp_next.producer_woken    = pwoken;
                    rsp_next.fill_count        = FILL_W'(cnt_next);
                    rsp_next.write_index       = IDX_W'(wpos_next);
                    rsp_next.read_index        = IDX_W'(rpos_next);
                    rsp_next.blocked_producers = BPROD_W'(wcnt_next);
                    rsp_next.blocked_consumers = cw_next;
                    rsp_valid_next             = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            op_reg        <= 1'b0;
            data_reg      <= '0;
            wpos_reg      <= '0;
            rpos_reg      <= '0;
            cnt_reg       <= '0;
            whead_reg     <= '0;
            wcnt_reg      <= '0;
            cw_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            op_reg        <= op_next;
            data_reg      <= data_next;
            wpos_reg      <= wpos_next;
            rpos_reg      <= rpos_next;
            cnt_reg       <= cnt_next;
            whead_reg     <= whead_next;
            wcnt_reg      <= wcnt_next;
            cw_reg        <= cw_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(BUFFER_DEPTH))
        else $error("ring fill count above depth");

    a_cons_wait_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cw_reg != '0) |-> (cnt_reg == '0))
        else $error("consumers waiting while ring holds data");

    a_prod_wait_full: assert property (@(posedge clk) disable iff (!rst_n)
        (wcnt_reg != '0) |-> ring_full)
        else $error("producers waiting while ring has room");

    a_rsp_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result raised without an executed transaction");

endmodule

`default_nettype wire
